// ===== hw/rtl/sk_pkg.sv =====
// Shared types and constants of the sorted key table.
// Holds the beat payload structs, status codes and the compare result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sk_pkg;

  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CNT_W    = 6;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [KEY_IN_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [CNT_W-1:0]   entry_count;
  } out_item_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sk_if.sv =====
// Valid/ready stream interfaces for the request and the result channel.
// Depends on sk_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sk_in_if import sk_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sk_out_if import sk_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sk_cmp.sv =====
// Shared key comparator used by every binary-search probe.
// Depends on sk_pkg for the compare result struct.
`timescale 1ns / 1ps
`default_nettype none

module sk_cmp import sk_pkg::*; #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic [KEY_WIDTH-1:0] a_i,
  input  wire logic [KEY_WIDTH-1:0] b_i,
  output cmp_t                      res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_table.sv =====
// Top level of the sorted key table: sequencer, key RAM and shared comparator.
// Depends on sk_pkg, sk_if, sk_ram and sk_cmp.
//
//   channel  dir  beat fields                          handshake
//   in_i     in   opcode, key                          valid / ready
//   out_o    out  status, position, entry_count        valid / ready
//
// Each binary-search probe is a RAM read followed by a compare; an insert or delete then
// moves the later entries one by one, and the single RAM port pair and the shared
// comparator serialise these steps.
// Reset clears the count and the control state; RAM contents are not cleared.
// A new beat is taken while a result waits on out_o; it completes once out_o drains.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table import sk_pkg::*; #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sk_in_if.sink     in_i,
  sk_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_CMP    = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_INSWR  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [OPC_W-1:0]       op_q, op_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          lo_q, lo_d;
  logic [CW-1:0]          hi_q, hi_d;
  logic [CW-1:0]          mid_q, mid_d;
  logic                   hit_q, hit_d;
  logic [AW-1:0]          rd_idx_q, rd_idx_d;
  logic [CW-1:0]          rem_q, rem_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          wr_addr_q, wr_addr_d;
  status_e                res_status_q, res_status_d;
  logic [POS_W-1:0]       res_pos_q, res_pos_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [KEY_WIDTH-1:0]   ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [KEY_WIDTH-1:0]   rd_data;
  cmp_t                   cmp_res;
  logic [CW-1:0]          mid_calc;
  logic [CW-1:0]          cnt_m1;
  logic [CW-1:0]          lo_p1;
  logic                   load_out;

  sk_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  sk_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .a_i   (rd_data),
    .b_i   (key_q),
    .res_o (cmp_res)
  );

  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);
  assign cnt_m1   = cnt_q - CW'(1);
  assign lo_p1    = lo_q + CW'(1);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    hit_d        = hit_q;
    rd_idx_d     = rd_idx_q;
    rem_d        = rem_q;
    pend_d       = pend_q;
    wr_addr_d    = wr_addr_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_addr_q;
    ram_wdata    = rd_data;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d      = in_i.payload.opcode;
          key_d     = KEY_WIDTH'(in_i.payload.key);
          lo_d      = '0;
          hi_d      = cnt_q;
          hit_d     = 1'b0;
          res_pos_d = '0;
          if (in_i.payload.opcode == OP_INSERT && cnt_q >= FULL_CNT) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else if (in_i.payload.opcode == OP_INSERT ||
                       in_i.payload.opcode == OP_DELETE ||
                       in_i.payload.opcode == OP_SEARCH) begin
            res_status_d = ST_OK;
            state_d      = S_SEARCH;
          end else begin
            res_status_d = ST_MISSING;
            state_d      = S_DONE;
          end
        end
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = mid_calc[AW-1:0];
          mid_d     = mid_calc;
          state_d   = S_CMP;
        end else begin
          res_pos_d = POS_W'(lo_q);
          pend_d    = 1'b0;
          if (op_q == OP_INSERT) begin
            if (hit_q) begin
              res_status_d = ST_DUP;
              res_pos_d    = '0;
              state_d      = S_DONE;
            end else begin
              rem_d    = cnt_q - lo_q;
              rd_idx_d = cnt_m1[AW-1:0];
              state_d  = S_SHIFT;
            end
          end else if (!hit_q) begin
            res_status_d = ST_MISSING;
            res_pos_d    = '0;
            state_d      = S_DONE;
          end else if (op_q == OP_SEARCH) begin
            state_d = S_DONE;
          end else begin
            rem_d    = cnt_m1 - lo_q;
            rd_idx_d = lo_p1[AW-1:0];
            state_d  = S_SHIFT;
          end
        end
      end
      S_CMP: begin
        if (cmp_res.lt) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d  = mid_q;
          hit_d = cmp_res.eq;
        end
        state_d = S_SEARCH;
      end
      S_SHIFT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = rd_data;
        end
        if (rem_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q;
          pend_d    = 1'b1;
          rem_d     = rem_q - CW'(1);
          if (op_q == OP_INSERT) begin
            wr_addr_d = rd_idx_q + AW'(1);
            rd_idx_d  = rd_idx_q - AW'(1);
          end else begin
            wr_addr_d = rd_idx_q - AW'(1);
            rd_idx_d  = rd_idx_q + AW'(1);
          end
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (op_q == OP_INSERT) begin
              state_d = S_INSWR;
            end else begin
              cnt_d   = cnt_m1;
              state_d = S_DONE;
            end
          end
        end
      end
      S_INSWR: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = key_q;
        cnt_d     = cnt_q + CW'(1);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (load_out) begin
      out_d.status      = res_status_q;
      out_d.position    = res_pos_q;
      out_d.entry_count = CNT_W'(cnt_q);
    end
  end

  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    hit_q        <= hit_d;
    rd_idx_q     <= rd_idx_d;
    wr_addr_q    <= wr_addr_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_q        <= out_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("Entry count exceeds the table depth.");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (lo_q <= hi_q && hi_q <= cnt_q))
    else $error("Binary-search window left the stored range.");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("Shift read and write hit the same RAM entry.");

  a_err_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> (out_q.position == '0))
    else $error("Failed beat reports a nonzero position.");

  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SHIFT && state_q != S_INSWR) |=> $stable(cnt_q))
    else $error("Entry count changed outside a table update.");

endmodule

`default_nettype wire

// ===== tb/sv/sk_checker.sv =====
// Checker for the sorted key table: watches the request and result channels,
// predicts each result from its own copy of the table and compares every field.
// Depends on sk_pkg and on the interfaces in sk_if.
`timescale 1ns / 1ps

module sk_checker import sk_pkg::*; #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  sk_in_if     req_i,
  sk_out_if    res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [KEY_IN_W-1:0] KeyMask =
      (KEY_WIDTH >= KEY_IN_W) ? {KEY_IN_W{1'b1}} : ((KEY_IN_W'(1) << KEY_WIDTH) - 1'b1);

  logic [KEY_IN_W-1:0] table_keys [DEPTH];
  int unsigned         table_count;
  out_item_t           expected_results [$];
  int                  mismatches = 0;
  int                  pending = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic apply_table_op(input in_item_t req, output out_item_t res);
    logic [KEY_IN_W-1:0] k;
    int unsigned lo, hi, mid, at, i;
    k            = req.key & KeyMask;
    res.status   = ST_OK;
    res.position = '0;
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    at = lo;
    case (req.opcode)
      OP_INSERT: begin
        if (table_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (at < table_count && table_keys[at] == k) begin
          res.status = ST_DUP;
        end else begin
          for (i = table_count; i > at; i--) table_keys[i] = table_keys[i-1];
          table_keys[at] = k;
          table_count++;
          res.position = POS_W'(at);
        end
      end
      OP_DELETE, OP_SEARCH: begin
        if (at >= table_count || table_keys[at] != k) begin
          res.status = ST_MISSING;
        end else begin
          res.position = POS_W'(at);
          if (req.opcode == OP_DELETE) begin
            for (i = at; i + 1 < table_count; i++) table_keys[i] = table_keys[i+1];
            table_count--;
          end
        end
      end
      default: begin
        res.status = ST_MISSING;
      end
    endcase
    res.entry_count = CNT_W'(table_count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      table_count = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        apply_table_op(req_i.payload, want);
        expected_results.push_back(want);
      end
      if (res_i.valid && res_i.ready) begin
        got = res_i.payload;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected, status", 32'(got.status),
                          32'hffff_ffff);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.position !== want.position)
            report_mismatch("position", 32'(got.position), 32'(want.position));
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the sorted key table testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on sk_pkg, sk_if,
// sorted_key_table and sk_checker.
`timescale 1ns / 1ps

module testbench import sk_pkg::*; ();

  localparam int                 DEPTH        = 32;
  localparam int                 KEY_WIDTH    = 32;
  localparam int                 RANDOM_BEATS = 1900;
  localparam int                 PHASE_LEN    = 160;
  localparam int                 POOL_SIZE    = 48;
  localparam int                 LONG_HOLD    = 400;
  localparam int                 DRAIN_CYCLES = 100;
  localparam int                 IDLE_LIMIT   = 4000;
  localparam logic [OPC_W-1:0]   OP_UNUSED    = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sk_in_if  req_if ();
  sk_out_if res_if ();

  int fail_count;
  int pending_count;
  int sent_count  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];

  always #5 clk_i = ~clk_i;

  sorted_key_table #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  sk_checker #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_i       (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // Offers one request beat and returns at the edge where it is taken.
  task automatic send_beat(input logic [OPC_W-1:0] op, input logic [KEY_IN_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_if.valid          <= 1'b1;
    req_if.payload.opcode <= op;
    req_if.payload.key    <= key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    burst_left--;
    sent_count++;
  endtask

  function automatic logic [KEY_IN_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic logic [OPC_W-1:0] pick_op(input int phase);
    int r;
    int ins_lim;
    int del_lim;
    r = $urandom_range(0, 99);
    case (phase)
      0:       begin ins_lim = 75; del_lim = 87; end
      1:       begin ins_lim = 40; del_lim = 70; end
      default: begin ins_lim = 15; del_lim = 75; end
    endcase
    if (r < 2) return OP_UNUSED;
    if (r < ins_lim) return OP_INSERT;
    if (r < del_lim) return OP_DELETE;
    return OP_SEARCH;
  endfunction

  initial begin : stimulus
    int i;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h8000_0000;
    for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OP_SEARCH, 32'h0000_0005);
    send_beat(OP_DELETE, 32'h0000_0005);
    send_beat(OP_UNUSED, 32'h0000_0005);
    send_beat(OP_INSERT, 32'h8000_0000);
    send_beat(OP_INSERT, 32'h0000_0000);
    send_beat(OP_INSERT, 32'hffff_ffff);
    send_beat(OP_INSERT, 32'h7fff_ffff);
    send_beat(OP_INSERT, 32'hffff_fffe);
    send_beat(OP_INSERT, 32'h0000_0001);
    send_beat(OP_INSERT, 32'h0000_0000);
    send_beat(OP_INSERT, 32'hffff_ffff);
    send_beat(OP_SEARCH, 32'h0000_0000);
    send_beat(OP_SEARCH, 32'hffff_ffff);
    send_beat(OP_SEARCH, 32'h1234_5678);
    send_beat(OP_SEARCH, 32'h0000_0002);
    send_beat(OP_DELETE, 32'h7fff_ffff);
    send_beat(OP_DELETE, 32'h0000_0000);
    send_beat(OP_DELETE, 32'hffff_ffff);
    send_beat(OP_DELETE, 32'h0000_0000);
    send_beat(OP_UNUSED, 32'h0000_0001);
    send_beat(OP_SEARCH, 32'h0000_0001);
    send_beat(OP_INSERT, 32'h5555_5555);
    send_beat(OP_INSERT, 32'haaaa_aaaa);

    for (i = 0; i < RANDOM_BEATS; i++) send_beat(pick_op((i / PHASE_LEN) % 3), pick_key());
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // The receiver stalls in spans of differing shape; once, it holds off long
  // enough that the block fills up and stops taking request beats.
  initial begin : result_sink
    int  mode;
    int  span;
    int  k;
    bit  held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && sent_count > 300) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode = $urandom_range(0, 9);
      span = $urandom_range(10, 150);
      for (k = 0; k < span; k++) begin
        case (mode)
          0, 1, 2: res_if.ready <= 1'b1;
          3, 4, 5, 6: res_if.ready <= $urandom_range(0, 1);
          7, 8: res_if.ready <= ($urandom_range(0, 4) != 0);
          default: res_if.ready <= ((k % 8) < 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/sk_pkg.sv
hw/rtl/sk_if.sv
hw/rtl/sk_ram.sv
hw/rtl/sk_cmp.sv
hw/rtl/sorted_key_table.sv
tb/sv/sk_checker.sv
tb/sv/testbench.sv
